@@ sv/wts_pkg.sv @@
package wts_pkg;

    localparam int STEP_W      = 20;
    localparam int LEVEL_W     = 12;
    localparam int CMD_W       = 2;
    localparam int LETTER_W    = 8;
    localparam int INT_W       = 10;
    localparam int SAMPLE_W    = 16;
    localparam int NOTE_W      = 3;
    localparam int NOTE_COUNT  = 7;
    localparam int CFG_INDEX_W = 3;

    typedef logic [STEP_W-1:0]          step_t;
    typedef logic [LEVEL_W-1:0]         level_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PLAY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    // note codes double as step register indexes
    typedef enum logic [NOTE_W-1:0] {
        NOTE_C = 3'd0,
        NOTE_D = 3'd1,
        NOTE_E = 3'd2,
        NOTE_F = 3'd3,
        NOTE_G = 3'd4,
        NOTE_A = 3'd5,
        NOTE_B = 3'd6
    } note_t;

    localparam logic [LETTER_W-1:0] LETTER_A = 8'h41;
    localparam logic [LETTER_W-1:0] LETTER_B = 8'h42;
    localparam logic [LETTER_W-1:0] LETTER_D = 8'h44;
    localparam logic [LETTER_W-1:0] LETTER_E = 8'h45;
    localparam logic [LETTER_W-1:0] LETTER_F = 8'h46;
    localparam logic [LETTER_W-1:0] LETTER_G = 8'h47;

    localparam step_t STEP_RESET [NOTE_COUNT] = '{
        20'd363308, 20'd363308, 20'd432049, 20'd457740,
        20'd513796, 20'd576716, 20'd647342
    };

    localparam level_t LEVEL_OFFSET = 12'd2048;

    localparam longint unsigned LOW32       = 64'h0000_0000_FFFF_FFFF;
    // pi/2 in unsigned Q2.62
    localparam longint unsigned HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam longint unsigned FULL_SCALE  = 64'd32767;

    function automatic note_t letter_to_note(input logic [LETTER_W-1:0] letter);
        note_t note;
        case (letter)
            LETTER_D: note = NOTE_D;
            LETTER_E: note = NOTE_E;
            LETTER_F: note = NOTE_F;
            LETTER_G: note = NOTE_G;
            LETTER_A: note = NOTE_A;
            LETTER_B: note = NOTE_B;
            default:  note = NOTE_C;
        endcase
        return note;
    endfunction

    // (a*b) >> 62, table build only
    function automatic longint unsigned mul_q62(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = a & LOW32;
        ah  = a >> 32;
        bl  = b & LOW32;
        bh  = b >> 32;
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + (lh & LOW32) + (hl & LOW32);
        lo  = (mid << 32) | (ll & LOW32);
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 2) | (lo >> 62);
    endfunction

    // floor(32767 * sin(pi/2 * r / Entries)) by taylor series in Q62
    function automatic int quarter_sine(input longint unsigned r,
                                        input longint unsigned Entries);
        longint unsigned theta, t2, term, sum, hi, lo, k, Denom;
        int result;
        result = 0;
        if (r == 0) begin
            result = 0;
        end else if (r >= Entries) begin
            result = 32767;
        end else begin
            theta = (HALF_PI_Q62 / Entries) * r + ((HALF_PI_Q62 % Entries) * r) / Entries;
            t2    = mul_q62(theta, theta);
            term  = theta;
            sum   = theta;
            k     = 1;
            while (k < 40 && term != 0) begin
                Denom = (2 * k) * (2 * k + 1);
                term  = mul_q62(term, t2) / Denom;
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
                k = k + 1;
            end
            hi     = sum >> 31;
            lo     = sum & 64'h7FFF_FFFF;
            result = int'((hi * FULL_SCALE + ((lo * FULL_SCALE) >> 31)) >> 31);
        end
        return result;
    endfunction

    function automatic sample_t sine_sample(input longint unsigned x,
                                            input longint unsigned Entries);
        longint unsigned a, q, r;
        int v;
        a = 4 * x;
        q = a / Entries;
        r = a % Entries;
        if (q[0]) begin
            r = Entries - r;
        end
        v = quarter_sine(r, Entries);
        if (q >= 2) begin
            v = -v;
        end
        return sample_t'(v);
    endfunction

endpackage

@@ sv/wts_sine_rom.sv @@
module wts_sine_rom #(
    parameter int TABLE_ENTRIES = 1000
) (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [wts_pkg::INT_W-1:0]         rd_addr,
    output wts_pkg::sample_t                  rd_data
);

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef wts_pkg::sample_t sine_table_t [TABLE_ENTRIES];

    function automatic sine_table_t build_table();
        sine_table_t tbl;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl[i] = wts_pkg::sine_sample(longint'(i), longint'(TABLE_ENTRIES));
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_table();

    wts_pkg::sample_t rd_data_reg;

    // addresses past the table read as zero
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (rd_addr < wts_pkg::INT_W'(TABLE_ENTRIES)) begin
                rd_data_reg <= SINE_TABLE[rd_addr[ADDR_W-1:0]];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/wavetable_tone_synthesizer_unit.sv @@
// Sine tone generator by direct digital synthesis. Command words on the s_ channel: a tick
// advances the phase accumulator by the step of the selected note, folds it back once at the
// table size and emits one 12-bit DAC level on the m_ channel (0 while sound is off); play
// selects a note by its ASCII letter (anything but C..B picks C) and turns sound on; stop turns
// it off; play, stop and code 3 emit nothing. One word is taken every cycle unless a tick
// waits behind a stalled m_ channel; the phase add and the registered sine ROM read happen in
// the cycle a tick is taken, and the output register then holds the level on the m_ channel
// until it is taken. The per-note steps sit on the cfg_ port, index 0..6 for C, D, E, F, G,
// A, B; the user must write them only while the block is idle; the block does not enforce it.
module wavetable_tone_synthesizer_unit #(
    parameter int TABLE_ENTRIES = 1000,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wts_pkg::CMD_W-1:0]           s_command,
    input  logic [wts_pkg::LETTER_W-1:0]        s_note_letter,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wts_pkg::LEVEL_W-1:0]         m_dac_level,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wts_pkg::STEP_W-1:0]          cfg_data
);

    localparam int ACC_W = FRACTION_BITS + wts_pkg::INT_W;
    localparam int SUM_W = ((ACC_W > wts_pkg::STEP_W) ? ACC_W : wts_pkg::STEP_W) + 1;
    localparam logic [wts_pkg::INT_W-1:0] WRAP_INT = wts_pkg::INT_W'(TABLE_ENTRIES);
    localparam logic [ACC_W-1:0] WRAP_ACC = {WRAP_INT, {FRACTION_BITS{1'b0}}};

    wts_pkg::step_t   step_reg [wts_pkg::NOTE_COUNT];
    logic [ACC_W-1:0] phase_reg, phase_next;
    wts_pkg::note_t   note_reg;
    logic             sound_reg;

    logic             tick_valid_reg;
    logic             tick_sound_reg;
    logic             out_valid_reg;
    wts_pkg::level_t  out_level_reg, out_level_next;

    logic             accept, tick, out_advance;
    wts_pkg::step_t   step_sel;
    logic [SUM_W-1:0] phase_sum;
    logic [ACC_W-1:0] phase_add;
    wts_pkg::sample_t rom_data;
    logic signed [wts_pkg::SAMPLE_W:0] biased;
    logic signed [wts_pkg::SAMPLE_W:0] quotient;

    assign out_advance = !out_valid_reg || m_ready;
    assign s_ready     = !tick_valid_reg || out_advance;
    assign accept      = s_valid && s_ready;
    assign tick        = accept && (s_command == wts_pkg::CMD_TICK);
    assign cfg_ready   = 1'b1;

    // phase advance and single fold back at the table size
    always_comb begin
        step_sel  = step_reg[note_reg];
        phase_sum = SUM_W'(phase_reg) + SUM_W'(step_sel);
        phase_add = phase_sum[ACC_W-1:0];
        if (phase_add[ACC_W-1:FRACTION_BITS] >= WRAP_INT) begin
            phase_next = phase_add - WRAP_ACC;
        end else begin
            phase_next = phase_add;
        end
    end

    wts_sine_rom #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_sine_rom (
        .aclk    (aclk),
        .rd_en   (tick),
        .rd_addr (phase_next[ACC_W-1:FRACTION_BITS]),
        .rd_data (rom_data)
    );

    // divide by 16 rounding toward zero, then offset to mid scale; 0 while sound is off
    always_comb begin
        biased   = {rom_data[wts_pkg::SAMPLE_W-1], rom_data}
                 + (rom_data[wts_pkg::SAMPLE_W-1] ? 17'sd15 : 17'sd0);
        quotient = biased >>> 4;
        if (tick_sound_reg) begin
            out_level_next = wts_pkg::LEVEL_W'(quotient) + wts_pkg::LEVEL_OFFSET;
        end else begin
            out_level_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < wts_pkg::NOTE_COUNT; i++) begin
                step_reg[i] <= wts_pkg::STEP_RESET[i];
            end
        end else if (cfg_valid && cfg_ready
                     && cfg_index < wts_pkg::CFG_INDEX_W'(wts_pkg::NOTE_COUNT)) begin
            step_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            note_reg  <= wts_pkg::NOTE_C;
            sound_reg <= 1'b0;
        end else if (accept) begin
            case (s_command)
                wts_pkg::CMD_TICK: phase_reg <= phase_next;
                wts_pkg::CMD_PLAY: begin
                    note_reg  <= wts_pkg::letter_to_note(s_note_letter);
                    sound_reg <= 1'b1;
                end
                wts_pkg::CMD_STOP: sound_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // rom read stage, then output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg <= 1'b0;
            tick_sound_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                tick_valid_reg <= tick;
                tick_sound_reg <= sound_reg;
            end
            if (out_advance) begin
                out_valid_reg <= tick_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance && tick_valid_reg) begin
            out_level_reg <= out_level_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_dac_level = out_level_reg;

endmodule
